// ----- rtl/udir_pkg.sv -----
package udir_pkg;

	localparam int NUM_SLOTS        = 8;
	localparam int MAX_OBJECT_BYTES = 256;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SIZE_W = $clog2(MAX_OBJECT_BYTES + 1);

	localparam logic [1:0] REQ_SET    = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_INFO   = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISSING  = 3'd1;
	localparam logic [2:0] ST_BADARG   = 3'd2;
	localparam logic [2:0] ST_DENIED   = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_STORFAIL = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] object_id;
		logic [31:0] byte_count;
		logic [31:0] read_offset;
		logic [31:0] create_options;
		logic        payload_write_ok;
		logic        index_write_ok;
		logic        payload_read_ok;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot_index;
		logic [8:0]  stored_size;
		logic [31:0] stored_options;
		logic [8:0]  granted_length;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_sts_t;

endpackage

// ----- rtl/uid_slot_directory.sv -----
// Object id directory over NUM_SLOTS slots. A request is taken when start is high and
// busy is low; its result appears on rsp for exactly one cycle with done high and must
// be captured then, since the block cannot be stalled. The lookup walks the slot table
// one entry per cycle and stops at the first id match or after the last slot; a finish
// state then registers the result, busy is low again when done is shown, and a new
// request may be started in the same cycle that done is shown.
module uid_slot_directory (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  udir_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output udir_pkg::rsp_t rsp
);

	udir_pkg::dp_cmd_t cmd;
	udir_pkg::dp_sts_t sts;

	udir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	udir_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/udir_ctrl.sv -----
module udir_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output udir_pkg::dp_cmd_t cmd,
	input  udir_pkg::dp_sts_t sts
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/udir_dp.sv -----
module udir_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  udir_pkg::req_t    req,
	input  udir_pkg::dp_cmd_t cmd,
	output udir_pkg::dp_sts_t sts,
	output logic              done,
	output udir_pkg::rsp_t    rsp
);

	localparam int SLOT_W = udir_pkg::SLOT_W;
	localparam int SIZE_W = udir_pkg::SIZE_W;

	logic [63:0]       entry_id_q   [udir_pkg::NUM_SLOTS];
	logic [SIZE_W-1:0] entry_size_q [udir_pkg::NUM_SLOTS];
	logic [31:0]       entry_opts_q [udir_pkg::NUM_SLOTS];
	logic [udir_pkg::NUM_SLOTS-1:0] entry_valid_q;

	udir_pkg::req_t    req_q;
	logic [SLOT_W-1:0] idx_q;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic [SIZE_W-1:0] hit_size_q;
	logic [31:0]       hit_opts_q;
	logic              free_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic              done_q;
	udir_pkg::rsp_t    rsp_q;

	logic              match_now;
	logic              idx_last;
	udir_pkg::rsp_t    rsp_d;
	logic              wr_en;
	logic              clr_en;
	logic [SLOT_W-1:0] wr_slot;
	logic [32:0]       range_end;

	assign match_now = entry_valid_q[idx_q] && (entry_id_q[idx_q] == req_q.object_id);
	assign idx_last  = (idx_q == SLOT_W'(udir_pkg::NUM_SLOTS - 1));
	assign sts.scan_done = match_now || idx_last;

	// scan one slot per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + SLOT_W'(1);
			if (match_now) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= idx_q;
				hit_size_q <= entry_size_q[idx_q];
				hit_opts_q <= entry_opts_q[idx_q];
			end else if (!entry_valid_q[idx_q] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
	end

	assign range_end = {1'b0, req_q.byte_count} + {1'b0, req_q.read_offset};

	always_comb begin
		rsp_d   = '0;
		wr_en   = 1'b0;
		clr_en  = 1'b0;
		wr_slot = hit_q ? hit_idx_q : free_idx_q;
		if (req_q.req_type == udir_pkg::REQ_SET) begin
			if (req_q.byte_count > 32'(udir_pkg::MAX_OBJECT_BYTES)) begin
				rsp_d.status = udir_pkg::ST_FULL;
			end else if (hit_q && hit_opts_q[0]) begin
				rsp_d.status     = udir_pkg::ST_DENIED;
				rsp_d.slot_index = 3'(hit_idx_q);
			end else if (!hit_q && !free_q) begin
				rsp_d.status = udir_pkg::ST_FULL;
			end else begin
				rsp_d.slot_index = 3'(wr_slot);
				if (!req_q.payload_write_ok || !req_q.index_write_ok) begin
					rsp_d.status = udir_pkg::ST_STORFAIL;
				end else begin
					rsp_d.status = udir_pkg::ST_OK;
					wr_en        = 1'b1;
				end
			end
		end else if (!hit_q) begin
			rsp_d.status = udir_pkg::ST_MISSING;
		end else begin
			rsp_d.slot_index = 3'(hit_idx_q);
			unique case (req_q.req_type)
				udir_pkg::REQ_GET: begin
					if (!req_q.payload_read_ok) begin
						rsp_d.status = udir_pkg::ST_STORFAIL;
					end else if ((req_q.read_offset > 32'(hit_size_q)) ||
					             (range_end > 33'(hit_size_q))) begin
						rsp_d.status = udir_pkg::ST_BADARG;
					end else begin
						rsp_d.granted_length = 9'(req_q.byte_count);
					end
				end
				udir_pkg::REQ_INFO: begin
					rsp_d.stored_size    = 9'(hit_size_q);
					rsp_d.stored_options = hit_opts_q;
				end
				udir_pkg::REQ_REMOVE: begin
					if (hit_opts_q[0]) begin
						rsp_d.status = udir_pkg::ST_DENIED;
					end else if (!req_q.index_write_ok) begin
						rsp_d.status = udir_pkg::ST_STORFAIL;
					end else begin
						clr_en = 1'b1;
					end
				end
				default: begin
					rsp_d.status = udir_pkg::ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && wr_en) begin
			entry_id_q[wr_slot]   <= req_q.object_id;
			entry_size_q[wr_slot] <= SIZE_W'(req_q.byte_count);
			entry_opts_q[wr_slot] <= req_q.create_options;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish && wr_en) begin
				entry_valid_q[wr_slot] <= 1'b1;
			end else if (cmd.finish && clr_en) begin
				entry_valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- rtl/udir_chk.sv -----
module udir_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input udir_pkg::rsp_t rsp
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start work");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request ended without a result");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status <= udir_pkg::ST_STORFAIL))
		else $error("undefined status code");

endmodule

bind uid_slot_directory udir_chk u_udir_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// ----- sim/uid_slot_directory_test.sv -----
`timescale 1ns / 1ps

module uid_slot_directory_test;

	class dir_scoreboard;
		logic [63:0]      slot_id [udir_pkg::NUM_SLOTS];
		logic [8:0]       slot_size [udir_pkg::NUM_SLOTS];
		logic [31:0]      slot_opts [udir_pkg::NUM_SLOTS];
		bit               slot_used [udir_pkg::NUM_SLOTS];
		udir_pkg::rsp_t   awaited_rsp [$];
		int               errors;

		function new();
			for (int i = 0; i < udir_pkg::NUM_SLOTS; i++) begin
				slot_id[i] = '0;
				slot_size[i] = '0;
				slot_opts[i] = '0;
				slot_used[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function int find_id(logic [63:0] id);
			for (int i = 0; i < udir_pkg::NUM_SLOTS; i++) begin
				if (slot_used[i] && slot_id[i] == id)
					return i;
			end
			return -1;
		endfunction

		function int stored_size_of(logic [63:0] id);
			int s;
			s = find_id(id);
			return (s < 0) ? -1 : int'(slot_size[s]);
		endfunction

		// works out the reply to an accepted request and updates the directory copy
		function void note_request(udir_pkg::req_t r);
			udir_pkg::rsp_t o;
			int             s;
			logic [31:0]    sz;
			o = '0;
			o.status = udir_pkg::ST_OK;
			if (r.req_type == udir_pkg::REQ_SET) begin
				if (r.byte_count > udir_pkg::MAX_OBJECT_BYTES) begin
					o.status = udir_pkg::ST_FULL;
				end else begin
					s = find_id(r.object_id);
					if (s >= 0 && slot_opts[s][0]) begin
						o.status = udir_pkg::ST_DENIED;
						o.slot_index = 3'(s);
					end else begin
						if (s < 0) begin
							for (int i = udir_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
								if (!slot_used[i])
									s = i;
							end
						end
						if (s < 0) begin
							o.status = udir_pkg::ST_FULL;
						end else begin
							o.slot_index = 3'(s);
							if (!r.payload_write_ok || !r.index_write_ok) begin
								o.status = udir_pkg::ST_STORFAIL;
							end else begin
								slot_id[s] = r.object_id;
								slot_size[s] = r.byte_count[8:0];
								slot_opts[s] = r.create_options;
								slot_used[s] = 1'b1;
							end
						end
					end
				end
			end else begin
				s = find_id(r.object_id);
				if (s < 0) begin
					o.status = udir_pkg::ST_MISSING;
				end else begin
					o.slot_index = 3'(s);
					case (r.req_type)
						udir_pkg::REQ_GET: begin
							sz = 32'(slot_size[s]);
							if (!r.payload_read_ok)
								o.status = udir_pkg::ST_STORFAIL;
							else if (r.read_offset > sz || r.byte_count > sz - r.read_offset)
								o.status = udir_pkg::ST_BADARG;
							else
								o.granted_length = r.byte_count[8:0];
						end
						udir_pkg::REQ_INFO: begin
							o.stored_size = slot_size[s];
							o.stored_options = slot_opts[s];
						end
						default: begin
							if (slot_opts[s][0]) begin
								o.status = udir_pkg::ST_DENIED;
							end else if (!r.index_write_ok) begin
								o.status = udir_pkg::ST_STORFAIL;
							end else begin
								slot_id[s] = '0;
								slot_size[s] = '0;
								slot_opts[s] = '0;
								slot_used[s] = 1'b0;
							end
						end
					endcase
				end
			end
			awaited_rsp.push_back(o);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(udir_pkg::rsp_t got);
			udir_pkg::rsp_t w;
			if (awaited_rsp.size() == 0) begin
				$error("result beat with no request outstanding");
				errors++;
				return;
			end
			w = awaited_rsp.pop_front();
			compare("status", 32'(w.status), 32'(got.status));
			compare("slot_index", 32'(w.slot_index), 32'(got.slot_index));
			compare("stored_size", 32'(w.stored_size), 32'(got.stored_size));
			compare("stored_options", w.stored_options, got.stored_options);
			compare("granted_length", 32'(w.granted_length), 32'(got.granted_length));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	udir_pkg::req_t req = '0;
	logic busy;
	logic done;
	udir_pkg::rsp_t rsp;

	dir_scoreboard sb;
	logic [63:0]   common_ids [10];
	logic [63:0]   locked_ids [3];

	uid_slot_directory dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_response(rsp);
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic udir_pkg::req_t make_req(logic [1:0] t, logic [63:0] id,
			logic [31:0] cnt, logic [31:0] off, logic [31:0] opts, bit pw, bit iw, bit pr);
		udir_pkg::req_t r;
		r.req_type = t;
		r.object_id = id;
		r.byte_count = cnt;
		r.read_offset = off;
		r.create_options = opts;
		r.payload_write_ok = pw;
		r.index_write_ok = iw;
		r.payload_read_ok = pr;
		return r;
	endfunction

	// mostly requests on a small set of ids so that entries get hit, replaced and removed
	function automatic udir_pkg::req_t random_request();
		udir_pkg::req_t r;
		int             pick;
		int             sz;
		bit             locked;
		pick = $urandom_range(99);
		r.req_type = (pick < 35) ? udir_pkg::REQ_SET : (pick < 65) ? udir_pkg::REQ_GET :
			(pick < 80) ? udir_pkg::REQ_INFO : udir_pkg::REQ_REMOVE;
		r.byte_count = $urandom;
		r.read_offset = $urandom;
		r.create_options = $urandom;
		r.payload_write_ok = ($urandom_range(9) != 0);
		r.index_write_ok = ($urandom_range(9) != 0);
		r.payload_read_ok = ($urandom_range(9) != 0);
		locked = 1'b0;
		pick = $urandom_range(99);
		if (pick < 85) begin
			r.object_id = common_ids[$urandom_range(9)];
		end else if (pick < 92) begin
			r.object_id = locked_ids[$urandom_range(2)];
			locked = 1'b1;
		end else if (r.req_type == udir_pkg::REQ_SET) begin
			r.object_id = common_ids[$urandom_range(9)];
		end else begin
			r.object_id = {$urandom, $urandom};
		end
		case (r.req_type)
			udir_pkg::REQ_SET: begin
				pick = $urandom_range(99);
				if (pick < 80)
					r.byte_count = $urandom_range(0, udir_pkg::MAX_OBJECT_BYTES);
				else if (pick < 90)
					r.byte_count = $urandom_range(udir_pkg::MAX_OBJECT_BYTES,
						udir_pkg::MAX_OBJECT_BYTES + 1);
				// write-once only on a few reserved ids so the directory never clogs
				r.create_options[0] = locked ? 1'($urandom_range(1)) : 1'b0;
			end
			udir_pkg::REQ_GET: begin
				sz = sb.stored_size_of(r.object_id);
				if (sz >= 0 && $urandom_range(3) != 0) begin
					r.read_offset = $urandom_range(0, sz);
					r.byte_count = $urandom_range(0, sz - int'(r.read_offset));
					case ($urandom_range(7))
						0: r.byte_count = sz - int'(r.read_offset) + 1;
						1: r.read_offset = sz + 1;
						default: ;
					endcase
				end else if ($urandom_range(1)) begin
					r.read_offset = $urandom_range(0, 300);
					r.byte_count = $urandom_range(0, 300);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// holds one beat until the block takes it, then notes it for checking
	task automatic send(input udir_pkg::req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 1'b0;
		do begin
			@(negedge clk);
			n++;
		end while (sb.awaited_rsp.size() != 0 && n < 200);
	endtask

	task automatic run_directed();
		logic [63:0] id0;
		logic [63:0] ones;
		logic [63:0] ida;
		logic [63:0] idl;
		id0 = common_ids[0];
		ones = common_ids[1];
		ida = common_ids[2];
		idl = locked_ids[0];
		send(make_req(udir_pkg::REQ_INFO, id0, 0, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, id0, 256, 0, 32'hFFFF_FFFE, 1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, ones, 257, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, ones, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, ida, 0, 0, 0, 0, 1, 1));
		send(make_req(udir_pkg::REQ_SET, ida, 0, 0, 0, 1, 0, 1));
		send(make_req(udir_pkg::REQ_SET, ida, 10, 0, 32'h8000_0000, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, id0, 256, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, id0, 0, 256, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, id0, 0, 257, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, id0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, id0, 157, 100, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, id0, 1, 0, 0, 1, 1, 0));
		send(make_req(udir_pkg::REQ_INFO, id0, 0, 0, 0, 0, 0, 0));
		send(make_req(udir_pkg::REQ_SET, id0, 3, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_INFO, id0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, idl, 5, 0, 32'h1, 1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, idl, 6, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_REMOVE, idl, 0, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_REMOVE, ida, 0, 0, 0, 1, 0, 1));
		send(make_req(udir_pkg::REQ_REMOVE, ida, 0, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_REMOVE, ida, 0, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_GET, ida, 0, 0, 0, 1, 1, 1));
		send(make_req(udir_pkg::REQ_SET, ones, 0, 0, 0, 1, 1, 1));
	endtask

	task automatic run_random(input int count, input int idle_pct);
		udir_pkg::req_t r;
		for (int i = 0; i < count; i++) begin
			r = random_request();
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(negedge clk);
			end
			send(r);
		end
	endtask

	initial begin
		sb = new();
		common_ids = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_A5A5_A5A5_A5A5,
			64'h5A5A_5A5A_5A5A_5A5A, 64'h1, 64'h8000_0000_0000_0000,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
			64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFE};
		locked_ids = '{64'h10C0_0000_0000_0001, 64'h10C0_0000_0000_0002,
			64'hEF3F_FFFF_FFFF_FFFD};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		drain();
		run_random(550, 0);
		drain();
		run_random(550, 75);
		drain();
		run_random(550, 30);
		drain();
		repeat (12) @(negedge clk);
		if (sb.awaited_rsp.size() != 0) begin
			$error("%0d results never arrived", sb.awaited_rsp.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
